// ===== hdl/gcdm_pkg.sv =====
// gcdm_pkg: shared types and constants of the grid chamfer distance map unit
// used by gcdm_ctrl, gcdm_datapath and grid_chamfer_distance_map_unit
package gcdm_pkg;

    // default grid storage extent
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // extent registers are 7 bits wide, so coordinates never need more
    localparam int EXT_W  = 7;
    localparam int DIST_W = 20;
    localparam int STEP_W = 15;

    // function codes
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_COMPUTE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    // terrain classes that are not obstacles
    localparam logic [2:0] CLASS_FLAT   = 3'd0;
    localparam logic [2:0] CLASS_UNINIT = 3'd1;

    // configuration register indexes
    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_DIST  = 2'd1;
    localparam logic [1:0] REG_COLS      = 2'd2;
    localparam logic [1:0] REG_ROWS      = 2'd3;

    // sqrt(2) in Q2.30, split in halves for two narrow multiplies
    localparam logic [31:0] SQRT2_Q30 = 32'd1518500250;
    localparam logic [15:0] SQRT2_HI  = SQRT2_Q30[31:16];
    localparam logic [15:0] SQRT2_LO  = SQRT2_Q30[15:0];

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] col;
        logic [5:0] row;
        logic [2:0] terrain_class;
        logic [7:0] vegetation;
    } t_in;

    typedef struct packed {
        logic [19:0] distance;
        logic        status;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic ld;       // load transaction
        logic rq;       // read transaction, memory read issued
        logic rr;       // read transaction, data returned
        logic fin;      // result with zero distance and ok status
        logic rd_en;    // neighbour read during compute
        logic diag;     // neighbour is diagonal
        logic center;   // read is the cell itself
        logic init;     // start of a cell, minimum to threshold
        logic cell_wr;  // write back relaxed cell
        logic prep1;    // diagonal step, low partial product
        logic prep2;    // diagonal step, final sum
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic             out_valid;
        logic [EXT_W-1:0] cols;
        logic [EXT_W-1:0] rows;
    } t_sts;

endpackage

// ===== hdl/gcdm_ctrl.sv =====
// gcdm_ctrl: sequencer for load, read and the two raster passes of compute
// depends on gcdm_pkg
module gcdm_ctrl
    import gcdm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in              i_in,
    input  logic             i_out_ready,
    input  t_sts             i_sts,
    output logic             o_in_ready,
    output t_cmd             o_cmd,
    output logic [EXT_W-1:0] o_x,
    output logic [EXT_W-1:0] o_z
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_PRE1  = 3'd2;
    localparam logic [2:0] S_PRE2  = 3'd3;
    localparam logic [2:0] S_NB    = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [EXT_W-1:0] TWO  = EXT_W'(2);
    localparam logic [EXT_W-1:0] FOUR = EXT_W'(4);
    localparam logic [3:0]       K_CENTER = 4'd8;

    logic [2:0]       r_state, n_state;
    logic [EXT_W-1:0] r_x, n_x, r_z, n_z;
    logic [3:0]       r_k, n_k;
    logic             r_bwd, n_bwd;
    logic             accept;
    logic [EXT_W-1:0] x_last, z_last;
    logic [EXT_W-1:0] nb_x, nb_z;
    logic             nb_diag;

    assign o_in_ready = (r_state == S_IDLE) && (!i_sts.out_valid || i_out_ready);
    assign accept     = o_in_ready && i_in_valid;
    assign x_last     = i_sts.cols - TWO;
    assign z_last     = i_sts.rows - TWO;

    // neighbour offsets
    always_comb begin
        nb_x    = r_x;
        nb_z    = r_z;
        nb_diag = 1'b0;
        case (r_k)
            4'd0: begin nb_x = r_x - 1'b1; nb_z = r_z - 1'b1; nb_diag = 1'b1; end
            4'd1: begin nb_x = r_x - 1'b1; end
            4'd2: begin nb_x = r_x - 1'b1; nb_z = r_z + 1'b1; nb_diag = 1'b1; end
            4'd3: begin nb_z = r_z - 1'b1; end
            4'd4: begin nb_z = r_z + 1'b1; end
            4'd5: begin nb_x = r_x + 1'b1; nb_z = r_z - 1'b1; nb_diag = 1'b1; end
            4'd6: begin nb_x = r_x + 1'b1; end
            4'd7: begin nb_x = r_x + 1'b1; nb_z = r_z + 1'b1; nb_diag = 1'b1; end
            default: begin end
        endcase
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_z     = r_z;
        n_k     = r_k;
        n_bwd   = r_bwd;
        o_cmd   = '0;
        o_x     = {1'b0, i_in.col};
        o_z     = {1'b0, i_in.row};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.func)
                        FUNC_LOAD:    o_cmd.ld = 1'b1;
                        FUNC_READ: begin
                            o_cmd.rq = 1'b1;
                            n_state  = S_RD;
                        end
                        FUNC_COMPUTE: n_state = S_PRE1;
                        default:      o_cmd.fin = 1'b1;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rr = 1'b1;
                n_state  = S_IDLE;
            end
            S_PRE1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = S_PRE2;
            end
            S_PRE2: begin
                o_cmd.prep2 = 1'b1;
                n_x   = TWO;
                n_z   = TWO;
                n_k   = 4'd0;
                n_bwd = 1'b0;
                if (i_sts.cols < FOUR || i_sts.rows < FOUR) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_NB;
                end
            end
            S_NB: begin
                o_x          = nb_x;
                o_z          = nb_z;
                o_cmd.rd_en  = 1'b1;
                o_cmd.diag   = nb_diag;
                o_cmd.center = (r_k == K_CENTER);
                o_cmd.init   = (r_k == 4'd0);
                n_k          = r_k + 1'b1;
                if (r_k == K_CENTER) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_WR;
            S_WR: begin
                o_x           = r_x;
                o_z           = r_z;
                o_cmd.cell_wr = 1'b1;
                n_k           = 4'd0;
                n_state       = S_NB;
                // raster order, forward then backward
                if (!r_bwd) begin
                    if (r_z == z_last) begin
                        if (r_x == x_last) begin
                            n_bwd = 1'b1;
                            n_z   = z_last;
                        end else begin
                            n_x = r_x + 1'b1;
                            n_z = TWO;
                        end
                    end else begin
                        n_z = r_z + 1'b1;
                    end
                end else begin
                    if (r_z == TWO) begin
                        if (r_x == TWO) begin
                            n_state = S_DONE;
                        end else begin
                            n_x = r_x - 1'b1;
                            n_z = z_last;
                        end
                    end else begin
                        n_z = r_z - 1'b1;
                    end
                end
            end
            S_DONE: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_z     <= '0;
            r_k     <= '0;
            r_bwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_z     <= n_z;
            r_k     <= n_k;
            r_bwd   <= n_bwd;
        end
    end

endmodule

// ===== hdl/gcdm_datapath.sv =====
// gcdm_datapath: configuration registers, grid memory, step costs,
// neighbour minimum and result register; depends on gcdm_pkg
module gcdm_datapath
    import gcdm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  t_in              i_in,
    input  t_cmd             i_cmd,
    input  logic [EXT_W-1:0] i_x,
    input  logic [EXT_W-1:0] i_z,
    input  logic             i_out_ready,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output t_out             o_out
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROWS_A = AW'(MAX_ROWS);

    logic [9:0]        r_cell_size;
    logic [15:0]       r_max_dist;
    logic [EXT_W-1:0]  r_cols, r_rows;
    logic [EXT_W-1:0]  cols, rows;
    logic [DIST_W-1:0] thr;
    logic [13:0]       ls;
    logic [25:0]       r_plo;
    logic [25:0]       p_hi;
    logic [41:0]       ds_sum;
    logic [STEP_W-1:0] r_ds;
    logic [AW-1:0]     addr;
    logic              in_grid, obstacle;
    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] r_rd_data;
    logic              r_rd_vld, r_rd_diag, r_rd_center, r_rd_inside;
    logic [DIST_W-1:0] r_m, r_center;
    logic [DIST_W:0]   cand;
    logic              r_out_valid;
    t_out              r_out;

    // saturate extents to storage size
    assign cols = (int'(r_cols) > MAX_COLS) ? EXT_W'(MAX_COLS) : r_cols;
    assign rows = (int'(r_rows) > MAX_ROWS) ? EXT_W'(MAX_ROWS) : r_rows;
    assign thr  = {r_max_dist, 4'b0};
    assign ls   = {r_cell_size, 4'b0};

    assign in_grid  = (i_x < cols) && (i_z < rows);
    assign addr     = AW'(i_x) * ROWS_A + AW'(i_z);
    assign obstacle = (i_in.terrain_class != CLASS_FLAT &&
                       i_in.terrain_class != CLASS_UNINIT) || (i_in.vegetation != 8'd0);

    assign o_sts.out_valid = r_out_valid;
    assign o_sts.cols      = cols;
    assign o_sts.rows      = rows;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= 10'd50;
            r_max_dist  <= 16'd2000;
            r_cols      <= EXT_W'(64);
            r_rows      <= EXT_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CELL_SIZE: r_cell_size <= i_cfg_data[9:0];
                REG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                REG_COLS:      r_cols      <= i_cfg_data[EXT_W-1:0];
                REG_ROWS:      r_rows      <= i_cfg_data[EXT_W-1:0];
                default: begin end
            endcase
        end
    end

    // diagonal step, rounded cell_size * 16 * sqrt(2); low partial product on prep1, final sum on prep2
    assign p_hi   = 26'(r_cell_size) * 26'(SQRT2_HI);
    assign ds_sum = {p_hi, 16'b0} + 42'(r_plo) + (42'd1 << 25);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep1) begin
            r_plo <= 26'(r_cell_size) * 26'(SQRT2_LO);
        end
        if (i_cmd.prep2) begin
            r_ds <= ds_sum[26 +: STEP_W];
        end
    end

    // grid memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld && in_grid) begin
            mem[addr] <= obstacle ? '0 : thr;
        end else if (i_cmd.cell_wr && (r_m < r_center)) begin
            mem[addr] <= r_m;
        end
        if (i_cmd.rd_en || (i_cmd.rq && in_grid)) begin
            r_rd_data <= mem[addr];
        end
    end

    // read return flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
        r_rd_diag   <= i_cmd.diag;
        r_rd_center <= i_cmd.center;
        if (i_cmd.rq) begin
            r_rd_inside <= in_grid;
        end
    end

    // neighbour plus step, running minimum
    assign cand = {1'b0, r_rd_data} + (r_rd_diag ? (DIST_W+1)'(r_ds) : (DIST_W+1)'(ls));

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_m <= thr;
        end else if (r_rd_vld && !r_rd_center && (cand < {1'b0, r_m})) begin
            r_m <= cand[DIST_W-1:0];
        end
        if (r_rd_vld && r_rd_center) begin
            r_center <= r_rd_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld || i_cmd.rr || i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.ld) begin
            r_out.distance <= '0;
            r_out.status   <= !in_grid;
        end else if (i_cmd.rr) begin
            r_out.distance <= r_rd_inside ? r_rd_data : '0;
            r_out.status   <= !r_rd_inside;
        end else if (i_cmd.fin) begin
            r_out.distance <= '0;
            r_out.status   <= 1'b0;
        end
    end

endmodule

// ===== hdl/grid_chamfer_distance_map_unit.sv =====
// grid_chamfer_distance_map_unit: obstacle distance map over a terrain grid
// load: result the cycle after acceptance; one load per cycle unless output stalls
// read: via memory read register, then result register; no new request until done
// compute: two passes over the interior cells; per cell the single read port visits nine
//   cells, then one write back
// reset: synchronous active low; control registers reset; grid undefined until loaded
module grid_chamfer_distance_map_unit
    import gcdm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);

    t_cmd             cmd;
    t_sts             sts;
    logic [EXT_W-1:0] x, z;

    // sequencer
    gcdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in_data),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd),
        .o_x         (x),
        .o_z         (z)
    );

    // grid and arithmetic
    gcdm_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .i_x         (x),
        .i_z         (z),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule
